// ===== sv/tgd_pkg.sv =====
// Shared types, constants and helpers for the tap gesture detector.
package tgd_pkg;

    localparam int AXIS_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int CFG_WIDTH      = 16;
    localparam int ADDR_WIDTH     = 5;
    localparam int DATA_WIDTH     = 32;
    localparam int ZONE_SQ_WIDTH  = 2 * CFG_WIDTH;

    localparam logic [2:0] REG_VELOCITY_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_REBOUND_WINDOW     = 3'd1;
    localparam logic [2:0] REG_MAX_RISE           = 3'd2;
    localparam logic [2:0] REG_COOLDOWN_MIN       = 3'd3;
    localparam logic [2:0] REG_COOLDOWN_MAX       = 3'd4;
    localparam logic [2:0] REG_SETTLE_VELOCITY    = 3'd5;
    localparam logic [2:0] REG_RETURN_ZONE        = 3'd6;
    localparam logic [2:0] REG_MULTI_WINDOW       = 3'd7;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RISING   = 2'd1;
    localparam logic [1:0] PH_COOLDOWN = 2'd2;

    localparam logic [2:0] DIR_NONE = 3'd0;
    localparam logic [2:0] DIR_POSX = 3'd1;
    localparam logic [2:0] DIR_NEGX = 3'd2;
    localparam logic [2:0] DIR_POSY = 3'd3;
    localparam logic [2:0] DIR_NEGY = 3'd4;
    localparam logic [2:0] DIR_POSZ = 3'd5;
    localparam logic [2:0] DIR_NEGZ = 3'd6;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] velocity_threshold;
        logic [CFG_WIDTH-1:0] rebound_window_ms;
        logic [CFG_WIDTH-1:0] max_rise_ms;
        logic [CFG_WIDTH-1:0] cooldown_min_ms;
        logic [CFG_WIDTH-1:0] cooldown_max_ms;
        logic [CFG_WIDTH-1:0] settle_velocity;
        logic [CFG_WIDTH-1:0] return_zone;
        logic [CFG_WIDTH-1:0] multi_window_ms;
    } cfg_t;

    // Same axis, opposite sign.
    function automatic logic opposite(input logic [2:0] a, input logic [2:0] b);
        logic [2:0] am;
        logic [2:0] bm;
        am = a - 3'd1;
        bm = b - 3'd1;
        if (a == DIR_NONE || b == DIR_NONE || a > DIR_NEGZ || b > DIR_NEGZ)
            return 1'b0;
        return (am[2:1] == bm[2:1]) && (a != b);
    endfunction

endpackage

// ===== sv/tap_gesture_detector.sv =====
// Tap gesture detector top level: register port, axis lanes and merge stage.
// Takes one sample word per clock while the output is not stalled and returns one result
// word per sample: the lane registers hold per-axis changes and squares from three parallel
// lanes, and the merge stage combines them and updates the tap state in a single step,
// which sets the one-word-per-cycle rate. An output register lets the next sample in
// while a result waits. Registers are 16-bit at byte offsets 4*i; the user must write
// them only while no sample is in flight, as the block itself does not enforce it.
module tap_gesture_detector #(
    parameter int AXIS_WIDTH = tgd_pkg::AXIS_WIDTH_DEF,
    parameter int TIME_WIDTH = tgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tgd_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [tgd_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [tgd_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [AXIS_WIDTH-1:0]      trans_x,
    input  logic signed [AXIS_WIDTH-1:0]      trans_y,
    input  logic signed [AXIS_WIDTH-1:0]      trans_z,
    input  logic [TIME_WIDTH-1:0]             time_ms,
    input  logic                              take_event,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              event_ready,
    output logic [2:0]                        event_dir,
    output logic [3:0]                        event_count
);
    import tgd_pkg::*;

    cfg_t                      cfg_reg;
    logic [ZONE_SQ_WIDTH-1:0]  zone_sq_reg;
    logic [2:0]                reg_index;
    logic                      cfg_write;

    logic signed [AXIS_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic                      s1_valid_reg, s1_valid_next;
    logic [TIME_WIDTH-1:0]     s1_time_reg;
    logic                      s1_take_reg;
    logic                      in_accept;
    logic                      out_space;

    logic [AXIS_WIDTH-1:0]     diff_x, diff_y, diff_z;
    logic                      up_x, up_y, up_z;
    logic [2*AXIS_WIDTH-1:0]   sq_x, sq_y, sq_z;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_WIDTH-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            zone_sq_reg <= '0;
        end
        else
        begin
            zone_sq_reg <= cfg_reg.return_zone * cfg_reg.return_zone;
            if (cfg_write)
            begin
                case (reg_index)
                    REG_VELOCITY_THRESHOLD: cfg_reg.velocity_threshold <= pwdata[CFG_WIDTH-1:0];
                    REG_REBOUND_WINDOW:     cfg_reg.rebound_window_ms  <= pwdata[CFG_WIDTH-1:0];
                    REG_MAX_RISE:           cfg_reg.max_rise_ms        <= pwdata[CFG_WIDTH-1:0];
                    REG_COOLDOWN_MIN:       cfg_reg.cooldown_min_ms    <= pwdata[CFG_WIDTH-1:0];
                    REG_COOLDOWN_MAX:       cfg_reg.cooldown_max_ms    <= pwdata[CFG_WIDTH-1:0];
                    REG_SETTLE_VELOCITY:    cfg_reg.settle_velocity    <= pwdata[CFG_WIDTH-1:0];
                    REG_RETURN_ZONE:        cfg_reg.return_zone        <= pwdata[CFG_WIDTH-1:0];
                    REG_MULTI_WINDOW:       cfg_reg.multi_window_ms    <= pwdata[CFG_WIDTH-1:0];
                    default:                cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_VELOCITY_THRESHOLD: prdata = DATA_WIDTH'(cfg_reg.velocity_threshold);
            REG_REBOUND_WINDOW:     prdata = DATA_WIDTH'(cfg_reg.rebound_window_ms);
            REG_MAX_RISE:           prdata = DATA_WIDTH'(cfg_reg.max_rise_ms);
            REG_COOLDOWN_MIN:       prdata = DATA_WIDTH'(cfg_reg.cooldown_min_ms);
            REG_COOLDOWN_MAX:       prdata = DATA_WIDTH'(cfg_reg.cooldown_max_ms);
            REG_SETTLE_VELOCITY:    prdata = DATA_WIDTH'(cfg_reg.settle_velocity);
            REG_RETURN_ZONE:        prdata = DATA_WIDTH'(cfg_reg.return_zone);
            REG_MULTI_WINDOW:       prdata = DATA_WIDTH'(cfg_reg.multi_window_ms);
            default:                prdata = '0;
        endcase
    end

    assign in_ready      = !s1_valid_reg || out_space;
    assign in_accept     = in_valid && in_ready;
    assign s1_valid_next = in_accept ? 1'b1 : (out_space ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                prev_x_reg <= trans_x;
                prev_y_reg <= trans_y;
                prev_z_reg <= trans_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_time_reg <= time_ms;
            s1_take_reg <= take_event;
        end
    end

    tgd_lane #(.AXIS_WIDTH(AXIS_WIDTH)) u_lane_x (
        .clk      (clk),
        .load     (in_accept),
        .axis     (trans_x),
        .prev     (prev_x_reg),
        .diff_reg (diff_x),
        .up_reg   (up_x),
        .sq_reg   (sq_x)
    );

    tgd_lane #(.AXIS_WIDTH(AXIS_WIDTH)) u_lane_y (
        .clk      (clk),
        .load     (in_accept),
        .axis     (trans_y),
        .prev     (prev_y_reg),
        .diff_reg (diff_y),
        .up_reg   (up_y),
        .sq_reg   (sq_y)
    );

    tgd_lane #(.AXIS_WIDTH(AXIS_WIDTH)) u_lane_z (
        .clk      (clk),
        .load     (in_accept),
        .axis     (trans_z),
        .prev     (prev_z_reg),
        .diff_reg (diff_z),
        .up_reg   (up_z),
        .sq_reg   (sq_z)
    );

    tgd_ctrl #(
        .AXIS_WIDTH (AXIS_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .zone_sq     (zone_sq_reg),
        .s1_valid    (s1_valid_reg),
        .diff_x      (diff_x),
        .diff_y      (diff_y),
        .diff_z      (diff_z),
        .up_x        (up_x),
        .up_y        (up_y),
        .up_z        (up_z),
        .sq_x        (sq_x),
        .sq_y        (sq_y),
        .sq_z        (sq_z),
        .s1_time     (s1_time_reg),
        .s1_take     (s1_take_reg),
        .out_ready   (out_ready),
        .out_space   (out_space),
        .out_valid   (out_valid),
        .event_ready (event_ready),
        .event_dir   (event_dir),
        .event_count (event_count)
    );

endmodule

// ===== sv/tgd_lane.sv =====
// One axis lane: change against the previous sample, its sign, and the axis square.
module tgd_lane #(
    parameter int AXIS_WIDTH = tgd_pkg::AXIS_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      load,
    input  logic signed [AXIS_WIDTH-1:0] axis,
    input  logic signed [AXIS_WIDTH-1:0] prev,
    output logic [AXIS_WIDTH-1:0]     diff_reg,
    output logic                      up_reg,
    output logic [2*AXIS_WIDTH-1:0]   sq_reg
);
    import tgd_pkg::*;

    logic signed [AXIS_WIDTH:0]   delta;
    logic [AXIS_WIDTH:0]          delta_abs;
    logic [AXIS_WIDTH-1:0]        diff_next;
    logic [AXIS_WIDTH-1:0]        axis_abs;
    logic [2*AXIS_WIDTH-1:0]      sq_next;

    assign delta     = {axis[AXIS_WIDTH-1], axis} - {prev[AXIS_WIDTH-1], prev};
    assign delta_abs = delta[AXIS_WIDTH] ? (~delta + 1'b1) : delta;
    assign diff_next = delta_abs[AXIS_WIDTH-1:0];
    assign axis_abs  = axis[AXIS_WIDTH-1] ? (~axis + 1'b1) : axis;
    assign sq_next   = axis_abs * axis_abs;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diff_reg <= diff_next;
            up_reg   <= (axis > prev);
            sq_reg   <= sq_next;
        end
    end

endmodule

// ===== sv/tgd_ctrl.sv =====
// Merge stage: combines lane results, runs the phase and group logic, holds the output word.
module tgd_ctrl #(
    parameter int AXIS_WIDTH = tgd_pkg::AXIS_WIDTH_DEF,
    parameter int TIME_WIDTH = tgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tgd_pkg::cfg_t                      cfg,
    input  logic [tgd_pkg::ZONE_SQ_WIDTH-1:0]  zone_sq,
    input  logic                               s1_valid,
    input  logic [AXIS_WIDTH-1:0]              diff_x,
    input  logic [AXIS_WIDTH-1:0]              diff_y,
    input  logic [AXIS_WIDTH-1:0]              diff_z,
    input  logic                               up_x,
    input  logic                               up_y,
    input  logic                               up_z,
    input  logic [2*AXIS_WIDTH-1:0]            sq_x,
    input  logic [2*AXIS_WIDTH-1:0]            sq_y,
    input  logic [2*AXIS_WIDTH-1:0]            sq_z,
    input  logic [TIME_WIDTH-1:0]              s1_time,
    input  logic                               s1_take,
    input  logic                               out_ready,
    output logic                               out_space,
    output logic                               out_valid,
    output logic                               event_ready,
    output logic [2:0]                         event_dir,
    output logic [3:0]                         event_count
);
    import tgd_pkg::*;

    localparam int SQ_SUM_WIDTH = 2 * AXIS_WIDTH + 2;
    localparam int CMP_WIDTH    = (SQ_SUM_WIDTH > ZONE_SQ_WIDTH) ? SQ_SUM_WIDTH : ZONE_SQ_WIDTH;
    localparam int CHG_WIDTH    = (AXIS_WIDTH > CFG_WIDTH) ? AXIS_WIDTH : CFG_WIDTH;

    logic                  out_valid_reg, out_valid_next;
    logic                  event_ready_reg, event_ready_next;
    logic [2:0]            event_dir_reg, event_dir_next;
    logic [3:0]            event_count_reg, event_count_next;

    logic [1:0]            phase_reg, phase_next;
    logic                  primed_reg, primed_next;
    logic [2:0]            rise_dir_reg, rise_dir_next;
    logic [TIME_WIDTH-1:0] phase_start_reg, phase_start_next;
    logic [2:0]            group_dir_reg, group_dir_next;
    logic [3:0]            group_count_reg, group_count_next;
    logic [TIME_WIDTH-1:0] last_tap_reg, last_tap_next;
    logic                  pending_reg, pending_next;
    logic [2:0]            pending_dir_reg, pending_dir_next;
    logic [3:0]            pending_count_reg, pending_count_next;
    logic [2:0]            confirmed_dir_reg, confirmed_dir_next;
    logic [TIME_WIDTH-1:0] confirmed_time_reg, confirmed_time_next;

    logic                  load;
    logic [CMP_WIDTH-1:0]  sq_sum;
    logic                  at_rest;
    logic [AXIS_WIDTH-1:0] max_change;
    logic [1:0]            win;
    logic [AXIS_WIDTH-1:0] win_diff;
    logic [2:0]            tap_dir;

    assign out_space = !out_valid_reg || out_ready;
    assign load      = s1_valid && out_space;

    assign sq_sum  = CMP_WIDTH'(sq_x) + CMP_WIDTH'(sq_y) + CMP_WIDTH'(sq_z);
    assign at_rest = sq_sum < CMP_WIDTH'(zone_sq);

    always_comb
    begin
        max_change = diff_x;
        if (diff_y > max_change)
            max_change = diff_y;
        if (diff_z > max_change)
            max_change = diff_z;
    end

    always_comb
    begin
        win      = 2'd0;
        win_diff = diff_x;
        if (diff_y > win_diff)
        begin
            win      = 2'd1;
            win_diff = diff_y;
        end
        if (diff_z > win_diff)
        begin
            win      = 2'd2;
            win_diff = diff_z;
        end
        if (win != 2'd2 && diff_z != '0 &&
            {1'b0, win_diff} < {diff_z, 1'b0})
            win = 2'd2;
        case (win)
            2'd0:    tap_dir = up_x ? DIR_POSX : DIR_NEGX;
            2'd1:    tap_dir = up_y ? DIR_POSY : DIR_NEGY;
            default: tap_dir = up_z ? DIR_POSZ : DIR_NEGZ;
        endcase
    end

    always_comb
    begin
        logic [TIME_WIDTH-1:0] now;
        logic [TIME_WIDTH-1:0] el_phase;
        logic                  do_tap;
        now      = s1_time;
        el_phase = now - phase_start_reg;
        do_tap   = 1'b0;

        phase_next          = phase_reg;
        primed_next         = primed_reg;
        rise_dir_next       = rise_dir_reg;
        phase_start_next    = phase_start_reg;
        group_dir_next      = group_dir_reg;
        group_count_next    = group_count_reg;
        last_tap_next       = last_tap_reg;
        pending_next        = pending_reg;
        pending_dir_next    = pending_dir_reg;
        pending_count_next  = pending_count_reg;
        confirmed_dir_next  = confirmed_dir_reg;
        confirmed_time_next = confirmed_time_reg;

        // expired group
        if (group_count_next != '0 &&
            (now - last_tap_reg) >= TIME_WIDTH'(cfg.multi_window_ms))
        begin
            if (!pending_next)
            begin
                pending_next       = 1'b1;
                pending_dir_next   = group_dir_next;
                pending_count_next = group_count_next;
            end
            group_count_next = '0;
            group_dir_next   = DIR_NONE;
        end

        if (!primed_reg)
            primed_next = 1'b1;
        else
        begin
            case (phase_reg)
                PH_RISING:
                begin
                    if (at_rest)
                    begin
                        do_tap           = (rise_dir_reg != DIR_POSZ);
                        phase_next       = PH_COOLDOWN;
                        phase_start_next = now;
                    end
                    else if (el_phase > TIME_WIDTH'(cfg.max_rise_ms))
                        phase_next = PH_IDLE;
                end
                PH_COOLDOWN:
                begin
                    if (el_phase >= TIME_WIDTH'(cfg.cooldown_max_ms))
                        phase_next = PH_IDLE;
                    else if (el_phase >= TIME_WIDTH'(cfg.cooldown_min_ms) &&
                             CHG_WIDTH'(max_change) < CHG_WIDTH'(cfg.settle_velocity) &&
                             at_rest)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    if (CHG_WIDTH'(max_change) >= CHG_WIDTH'(cfg.velocity_threshold))
                    begin
                        if (confirmed_dir_reg != DIR_NONE &&
                            opposite(tap_dir, confirmed_dir_reg) &&
                            (now - confirmed_time_reg) < TIME_WIDTH'(cfg.rebound_window_ms))
                            phase_next = PH_COOLDOWN;
                        else
                        begin
                            rise_dir_next = tap_dir;
                            phase_next    = PH_RISING;
                        end
                        phase_start_next = now;
                    end
                end
            endcase
        end

        if (do_tap)
        begin
            confirmed_dir_next  = rise_dir_reg;
            confirmed_time_next = now;
            if (group_count_next != '0 && rise_dir_reg != group_dir_next)
            begin
                if (!pending_next)
                begin
                    pending_next       = 1'b1;
                    pending_dir_next   = group_dir_next;
                    pending_count_next = group_count_next;
                end
                group_count_next = '0;
            end
            group_dir_next = rise_dir_reg;
            if (group_count_next < COUNT_MAX)
                group_count_next = group_count_next + 4'd1;
            last_tap_next = now;
        end

        event_ready_next = pending_next;
        event_dir_next   = pending_next ? pending_dir_next : DIR_NONE;
        event_count_next = pending_next ? pending_count_next : 4'd0;

        if (s1_take)
            pending_next = 1'b0;
    end

    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_IDLE;
            primed_reg         <= 1'b0;
            rise_dir_reg       <= DIR_NONE;
            phase_start_reg    <= '0;
            group_dir_reg      <= DIR_NONE;
            group_count_reg    <= '0;
            last_tap_reg       <= '0;
            pending_reg        <= 1'b0;
            pending_dir_reg    <= DIR_NONE;
            pending_count_reg  <= '0;
            confirmed_dir_reg  <= DIR_NONE;
            confirmed_time_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                phase_reg          <= phase_next;
                primed_reg         <= primed_next;
                rise_dir_reg       <= rise_dir_next;
                phase_start_reg    <= phase_start_next;
                group_dir_reg      <= group_dir_next;
                group_count_reg    <= group_count_next;
                last_tap_reg       <= last_tap_next;
                pending_reg        <= pending_next;
                pending_dir_reg    <= pending_dir_next;
                pending_count_reg  <= pending_count_next;
                confirmed_dir_reg  <= confirmed_dir_next;
                confirmed_time_reg <= confirmed_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_ready_reg <= event_ready_next;
            event_dir_reg   <= event_dir_next;
            event_count_reg <= event_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_ready = event_ready_reg;
    assign event_dir   = event_dir_reg;
    assign event_count = event_count_reg;

    a_group_dir_set: assert property (@(posedge clk) disable iff (!rst_n)
        group_count_reg != '0 |-> group_dir_reg != DIR_NONE && group_dir_reg != DIR_POSZ)
        else $error("open group without a valid direction");

    a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> pending_count_reg != '0)
        else $error("pending event with zero taps");

    a_unprimed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> phase_reg == PH_IDLE && group_count_reg == '0)
        else $error("phase left idle before first sample");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !event_ready_reg |-> event_dir_reg == DIR_NONE && event_count_reg == '0)
        else $error("output word carries event data without an event");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the tap gesture detector: directed samples and random tap streams vs. a local model.
`timescale 1ns / 1ps

module tb_top;
    import tgd_pkg::*;

    localparam int AW = AXIS_WIDTH_DEF;
    localparam int TW = TIME_WIDTH_DEF;

    typedef struct {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
        logic [TW-1:0]        t;
        logic                 take;
    } sample_t;

    typedef struct {
        logic       ready;
        logic [2:0] dir;
        logic [3:0] count;
    } tap_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [AW-1:0] trans_x = '0;
    logic signed [AW-1:0] trans_y = '0;
    logic signed [AW-1:0] trans_z = '0;
    logic [TW-1:0]        time_ms = '0;
    logic                 take_event = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 event_ready;
    logic [2:0]           event_dir;
    logic [3:0]           event_count;

    tap_gesture_detector uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .trans_x    (trans_x),
        .trans_y    (trans_y),
        .trans_z    (trans_z),
        .time_ms    (time_ms),
        .take_event (take_event),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_ready(event_ready),
        .event_dir  (event_dir),
        .event_count(event_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // detector model state
    cfg_t          cfg_now = '0;
    logic [1:0]    det_phase = PH_IDLE;
    logic          det_primed = 1'b0;
    longint        prev_ax[3] = '{0, 0, 0};
    logic [2:0]    rise_dir = DIR_NONE;
    logic [TW-1:0] phase_t0 = '0;
    logic [2:0]    grp_dir = DIR_NONE;
    logic [3:0]    grp_cnt = '0;
    logic [TW-1:0] last_tap_t = '0;
    logic          pend_flag = 1'b0;
    logic [2:0]    pend_dir = DIR_NONE;
    logic [3:0]    pend_cnt = '0;
    logic [2:0]    conf_dir = DIR_NONE;
    logic [TW-1:0] conf_t = '0;

    sample_t    sample_q[$];
    tap_event_t event_q[$];
    sample_t    offer;
    tap_event_t want;
    int         words_outstanding = 0;
    int         queued_total = 0;
    int         results_seen = 0;
    int         hold_left = 0;
    int         errors = 0;
    bit         steady = 1'b0;

    // stimulus shaping
    logic [TW-1:0] clock_ms = '0;
    int            rest_span = 50;
    int            tap_axis = 0;
    bit            tap_neg = 1'b0;
    bit            rapid = 1'b0;
    int            noise_pct = 25;
    int            switch_pct = 30;

    function automatic logic reversed(input logic [2:0] a, input logic [2:0] b);
        return a != DIR_NONE && b != DIR_NONE && a <= DIR_NEGZ && b <= DIR_NEGZ &&
            ((a + 3'd1) >> 1) == ((b + 3'd1) >> 1) && a != b;
    endfunction

    task automatic close_group();
        if (!pend_flag)
        begin
            pend_flag = 1'b1;
            pend_dir = grp_dir;
            pend_cnt = grp_cnt;
        end
        grp_cnt = '0;
    endtask

    task automatic advance_detector(input sample_t s);
        longint          ax[3];
        longint unsigned dv[3];
        longint unsigned mag;
        longint unsigned zone_sq;
        longint unsigned peak;
        logic [TW-1:0]   since_tap;
        logic [TW-1:0]   since_phase;
        logic [TW-1:0]   since_conf;
        logic [2:0]      d;
        int              w;
        tap_event_t      r;
        ax[0] = $signed(s.x);
        ax[1] = $signed(s.y);
        ax[2] = $signed(s.z);
        zone_sq = cfg_now.return_zone;
        zone_sq = zone_sq * zone_sq;
        since_tap = s.t - last_tap_t;
        since_phase = s.t - phase_t0;
        since_conf = s.t - conf_t;
        mag = 0;
        peak = 0;
        w = 0;
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = (ax[i] >= prev_ax[i]) ? ax[i] - prev_ax[i] : prev_ax[i] - ax[i];
            mag += ax[i] * ax[i];
            if (dv[i] > peak)
                peak = dv[i];
            if (dv[i] > dv[w])
                w = i;
        end
        // Z takes over when its change is more than half the winner's
        if (w != 2 && dv[2] > 0 && dv[w] < 2 * dv[2])
            w = 2;
        d = 3'(2 * w + ((ax[w] > prev_ax[w]) ? 1 : 2));

        if (grp_cnt != 0 && since_tap >= cfg_now.multi_window_ms)
        begin
            close_group();
            grp_dir = DIR_NONE;
        end

        if (!det_primed)
            det_primed = 1'b1;
        else if (det_phase == PH_RISING)
        begin
            if (mag < zone_sq)
            begin
                if (rise_dir != DIR_POSZ)
                begin
                    conf_dir = rise_dir;
                    conf_t = s.t;
                    if (grp_cnt != 0 && rise_dir != grp_dir)
                        close_group();
                    grp_dir = rise_dir;
                    if (grp_cnt != COUNT_MAX)
                        grp_cnt++;
                    last_tap_t = s.t;
                end
                det_phase = PH_COOLDOWN;
                phase_t0 = s.t;
            end
            else if (since_phase > cfg_now.max_rise_ms)
                det_phase = PH_IDLE;
        end
        else if (det_phase == PH_COOLDOWN)
        begin
            if (since_phase >= cfg_now.cooldown_max_ms)
                det_phase = PH_IDLE;
            else if (since_phase >= cfg_now.cooldown_min_ms && peak < cfg_now.settle_velocity &&
                     mag < zone_sq)
                det_phase = PH_IDLE;
        end
        else if (peak >= cfg_now.velocity_threshold)
        begin
            if (conf_dir != DIR_NONE && reversed(d, conf_dir) &&
                since_conf < cfg_now.rebound_window_ms)
                det_phase = PH_COOLDOWN;
            else
            begin
                rise_dir = d;
                det_phase = PH_RISING;
            end
            phase_t0 = s.t;
        end

        for (int i = 0; i < 3; i++)
            prev_ax[i] = ax[i];

        r.ready = pend_flag;
        r.dir = pend_flag ? pend_dir : DIR_NONE;
        r.count = pend_flag ? pend_cnt : '0;
        event_q.push_back(r);
        if (s.take)
            pend_flag = 1'b0;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                advance_detector(offer);
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() > 0 && (steady || $urandom_range(99) >= 19))
                begin
                    offer = sample_q.pop_front();
                    trans_x <= offer.x;
                    trans_y <= offer.y;
                    trans_z <= offer.z;
                    time_ms <= offer.t;
                    take_event <= offer.take;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (event_q.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = event_q.pop_front();
                    words_outstanding--;
                    if (event_ready !== want.ready)
                    begin
                        $error("event_ready expected %0d got %0d", want.ready, event_ready);
                        errors++;
                    end
                    if (event_dir !== want.dir)
                    begin
                        $error("event_dir expected %0d got %0d", want.dir, event_dir);
                        errors++;
                    end
                    if (event_count !== want.count)
                    begin
                        $error("event_count expected %0d got %0d", want.count, event_count);
                        errors++;
                    end
                end
                results_seen++;
                if (results_seen == 760)
                    hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || $urandom_range(99) >= 19;
        end
    end

    function automatic logic signed [AW-1:0] clamp_axis(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return AW'(v);
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int wild();
        case ($urandom_range(3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic bit coin_take();
        return $urandom_range(4) == 0;
    endfunction

    task automatic add_sample(input int x, input int y, input int z, input int unsigned dt,
                              input bit take);
        sample_t s;
        clock_ms += dt;
        s.x = clamp_axis(x);
        s.y = clamp_axis(y);
        s.z = clamp_axis(z);
        s.t = clock_ms;
        s.take = take;
        sample_q.push_back(s);
        words_outstanding++;
        queued_total++;
    endtask

    // rest, spike, optional hold, return, settle
    task automatic add_tap();
        int a[3];
        int amp;
        int base;
        int step;
        int unsigned lead;
        int holds;
        base = (cfg_now.velocity_threshold > cfg_now.return_zone) ?
            int'(cfg_now.velocity_threshold) : int'(cfg_now.return_zone);
        amp = rapid ? int'($urandom_range(6000, 16000)) : base + int'($urandom_range(50, 4000));
        step = rapid ? $urandom_range(1, 3) : $urandom_range(1, 20);
        holds = rapid ? 0 : $urandom_range(3);
        if (rapid)
            lead = $urandom_range(5);
        else if ($urandom_range(3) == 0)
            lead = $urandom_range(2 * cfg_now.multi_window_ms + 20);
        else
            lead = $urandom_range(10);
        for (int i = 0; i < 3; i++)
            a[i] = jitter(rest_span);
        a[tap_axis] = tap_neg ? -amp : amp;
        if ($urandom_range(3) == 0)
            a[(tap_axis + 1) % 3] = jitter(amp);
        add_sample(a[0], a[1], a[2], lead, coin_take());
        repeat (holds)
            add_sample(a[0] + jitter(amp / 8), a[1], a[2] + jitter(amp / 8), step, coin_take());
        add_sample(jitter(rest_span), jitter(rest_span), jitter(rest_span), step, coin_take());
        repeat ($urandom_range(1, 4))
            add_sample(jitter(rest_span), jitter(rest_span), jitter(rest_span), step,
                       coin_take());
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input cfg_t c);
        write_reg(REG_VELOCITY_THRESHOLD, c.velocity_threshold);
        write_reg(REG_REBOUND_WINDOW, c.rebound_window_ms);
        write_reg(REG_MAX_RISE, c.max_rise_ms);
        write_reg(REG_COOLDOWN_MIN, c.cooldown_min_ms);
        write_reg(REG_COOLDOWN_MAX, c.cooldown_max_ms);
        write_reg(REG_SETTLE_VELOCITY, c.settle_velocity);
        write_reg(REG_RETURN_ZONE, c.return_zone);
        write_reg(REG_MULTI_WINDOW, c.multi_window_ms);
        cfg_now = c;
    endtask

    task automatic drain();
        wait (words_outstanding == 0);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        cfg_t c;
        int   plan[14];
        int   roll;
        int   goal;
        int   lo;
        plan = '{0, 0, 4, 1, 0, 2, 0, 3, 0, 4, 0, 3, 0, 0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values: zero threshold and zone
        add_sample(32767, -32768, 0, 0, 1'b0);
        add_sample(32767, -32768, 0, 0, 1'b1);
        add_sample(-32768, 32767, -32768, 32'hFFFF_FFFF, 1'b0);
        add_sample(0, 0, 0, 1, 1'b0);
        add_sample(0, 0, 0, 0, 1'b1);
        drain();

        c.velocity_threshold = 16'd1000;
        c.rebound_window_ms  = 16'd100;
        c.max_rise_ms        = 16'd50;
        c.cooldown_min_ms    = 16'd10;
        c.cooldown_max_ms    = 16'd60;
        c.settle_velocity    = 16'd200;
        c.return_zone        = 16'd500;
        c.multi_window_ms    = 16'd200;
        set_config(c);
        @(negedge clk);
        add_sample(0, 0, 0, 5, 1'b0);
        add_sample(0, 0, 0, 20, 1'b0);
        // positive Z tap is dropped
        add_sample(0, 0, 5000, 5, 1'b0);
        add_sample(0, 0, 0, 5, 1'b0);
        add_sample(0, 0, 0, 20, 1'b0);
        // tie between X and Y goes to X
        add_sample(3000, 3000, 0, 5, 1'b0);
        add_sample(0, 0, 0, 5, 1'b0);
        add_sample(0, 0, 0, 20, 1'b0);
        // reversed spike inside rebound window
        add_sample(-3000, 0, 0, 5, 1'b0);
        add_sample(0, 0, 0, 20, 1'b0);
        add_sample(0, 0, 0, 20, 1'b0);
        // Z preference, new direction closes the group
        add_sample(2000, 0, -1500, 5, 1'b0);
        add_sample(0, 0, 0, 5, 1'b1);
        add_sample(0, 0, 0, 20, 1'b0);
        // group expires after multi-tap window
        add_sample(0, 0, 0, 300, 1'b0);
        add_sample(0, 0, 0, 5, 1'b1);
        add_sample(0, 0, 0, 5, 1'b0);

        for (int p = 0; p < 14; p++)
        begin
            drain();
            rapid = 1'b0;
            noise_pct = 25;
            switch_pct = 30;
            case (plan[p])
                1:
                begin
                    c = '0;
                    rest_span = 50;
                end
                2:
                begin
                    c = '1;
                    rest_span = 2000;
                end
                3:
                begin
                    c = {$urandom(), $urandom(), $urandom(), $urandom()};
                    rest_span = 100;
                end
                4:
                begin
                    c.velocity_threshold = 16'd5000;
                    c.rebound_window_ms  = 16'd0;
                    c.max_rise_ms        = 16'hFFFF;
                    c.cooldown_min_ms    = 16'd0;
                    c.cooldown_max_ms    = 16'd0;
                    c.settle_velocity    = 16'd0;
                    c.return_zone        = 16'hFFFF;
                    c.multi_window_ms    = 16'hFFFF;
                    rest_span = 20;
                    rapid = 1'b1;
                    noise_pct = 5;
                    switch_pct = 4;
                end
                default:
                begin
                    c.velocity_threshold = $urandom_range(300, 4000);
                    c.rebound_window_ms  = $urandom_range(0, 150);
                    c.max_rise_ms        = $urandom_range(0, 80);
                    c.cooldown_min_ms    = $urandom_range(0, 40);
                    c.cooldown_max_ms    = $urandom_range(0, 120);
                    c.settle_velocity    = $urandom_range(100, 3000);
                    c.return_zone        = $urandom_range(100, 2000);
                    c.multi_window_ms    = $urandom_range(20, 300);
                    lo = (c.return_zone < c.settle_velocity) ?
                        int'(c.return_zone) : int'(c.settle_velocity);
                    rest_span = lo / 4;
                end
            endcase
            set_config(c);
            steady = (p == 6);
            goal = queued_total + 135;
            @(negedge clk);
            while (queued_total < goal)
            begin
                roll = $urandom_range(99);
                if (roll >= noise_pct)
                begin
                    if ($urandom_range(99) < switch_pct)
                    begin
                        tap_axis = $urandom_range(2);
                        tap_neg = $urandom_range(1);
                    end
                    add_tap();
                end
                else if (roll < noise_pct / 2)
                    add_sample(wild(), wild(), wild(),
                               ($urandom_range(15) == 0) ? $urandom() : $urandom_range(40),
                               coin_take());
                else
                    add_sample(jitter(32767), jitter(rest_span), jitter(rest_span),
                               $urandom_range(60), coin_take());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (event_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", event_q.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
